FILE: design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the parameter set extractor: the input and
// result beat layouts, the per-item result bundle and the unit kind codes.
// ----------------------------------------------------------------------------
package pse_pkg;

  // results one input item can cause at most
  localparam int MaxResults = 5;
  localparam int ResCntW    = $clog2(MaxResults + 1);
  localparam int ResIdxW    = $clog2(MaxResults);

  // nal unit type codes (low five bits of the header byte)
  localparam logic [4:0] NalTypeSps = 5'd7;
  localparam logic [4:0] NalTypePps = 5'd8;

  // start code bytes
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // configuration register indexes
  localparam logic CfgSpsKnown = 1'b0;
  localparam logic CfgPpsKnown = 1'b1;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_SPS   = 2'd1,
    KIND_PPS   = 2'd2
  } unit_kind_e;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } pse_in_t;

  // result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       set_kind;
    logic       unit_first;
    logic       unit_last;
    logic       scan_done;
    logic       both_found;
    logic       last_result;
  } pse_out_t;

  // all results caused by one input item, entry 0 first
  typedef struct packed {
    pse_out_t [MaxResults-1:0] res;
    logic [ResCntW-1:0]        count;
  } pse_bundle_t;

endpackage

FILE: design/pse_step.sv
// ----------------------------------------------------------------------------
// pse_step
// Scan state of the extractor and the single-pass logic that turns one
// buffered byte into its bundle of results; the state advances on load.
// ----------------------------------------------------------------------------
module pse_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pse_pkg::pse_in_t     item_i,
  input  logic                 sps_known_i,
  input  logic                 pps_known_i,
  output pse_pkg::pse_bundle_t bundle_o
);
  import pse_pkg::*;

  typedef struct packed {
    logic [7:0] held_byte;
    logic [1:0] zero_run;
    logic       inside_unit;
    logic       expect_header;
    logic       head_pending;
    unit_kind_e unit_kind;
    logic       sps_seen;
    logic       pps_seen;
    logic       scan_finished;
    logic       in_buffer;
  } scan_state_t;

  scan_state_t state_q, state_d;
  pse_bundle_t bundle;

  // append one payload result unless the unit is of no interest
  function automatic pse_bundle_t push(pse_bundle_t bu, unit_kind_e kind,
                                       logic [7:0] b, logic first, logic last);
    pse_bundle_t r;
    r = bu;
    if (kind != KIND_OTHER && bu.count < ResCntW'(MaxResults)) begin
      r.res[ResIdxW'(bu.count)] = '{byte_valid: 1'b1, out_byte: b,
                                    set_kind: (kind == KIND_PPS),
                                    unit_first: first, unit_last: last,
                                    scan_done: 1'b0, both_found: 1'b0,
                                    last_result: 1'b0};
      r.count = ResCntW'(bu.count + 1'b1);
    end
    return r;
  endfunction

  // mark the current unit as ended and note its kind
  function automatic scan_state_t close_unit(scan_state_t st);
    scan_state_t r;
    r = st;
    if (st.unit_kind == KIND_SPS) begin
      r.sps_seen = 1'b1;
    end else if (st.unit_kind == KIND_PPS) begin
      r.pps_seen = 1'b1;
    end
    if (r.sps_seen && r.pps_seen) begin
      r.scan_finished = 1'b1;
    end
    r.inside_unit  = 1'b0;
    r.head_pending = 1'b0;
    r.zero_run     = 2'd0;
    return r;
  endfunction

  // one byte of the scan
  always_comb begin
    logic [7:0]         b;
    logic [4:0]         hdr_type;
    logic [ResIdxW-1:0] tail;
    b        = item_i.data_byte;
    hdr_type = b[4:0];
    state_d  = state_q;
    bundle   = '0;
    tail     = '0;

    // first byte of a buffer reloads the known flags
    if (!state_d.in_buffer) begin
      state_d.in_buffer = 1'b1;
      state_d.sps_seen  = sps_known_i;
      state_d.pps_seen  = pps_known_i;
    end

    if (!state_d.scan_finished) begin
      if (state_d.expect_header) begin
        // header byte opens a unit
        state_d.expect_header = 1'b0;
        state_d.inside_unit   = 1'b1;
        state_d.held_byte     = b;
        state_d.head_pending  = 1'b1;
        state_d.zero_run      = 2'd0;
        if (hdr_type == NalTypeSps) begin
          state_d.unit_kind = KIND_SPS;
        end else if (hdr_type == NalTypePps) begin
          state_d.unit_kind = KIND_PPS;
        end else begin
          state_d.unit_kind = KIND_OTHER;
        end
      end else if (state_d.inside_unit) begin
        if (b == ByteZero) begin
          // zero run of undecided fate, excess zeros go into the unit
          if (state_d.zero_run != 2'd3) begin
            state_d.zero_run = state_d.zero_run + 2'd1;
          end else begin
            bundle = push(bundle, state_d.unit_kind, state_d.held_byte,
                          state_d.head_pending, 1'b0);
            state_d.head_pending = 1'b0;
            state_d.held_byte    = ByteZero;
          end
        end else if (b == ByteOne && state_d.zero_run >= 2'd2) begin
          // start code ends the unit, its zeros belong to no unit
          bundle = push(bundle, state_d.unit_kind, state_d.held_byte,
                        state_d.head_pending, 1'b1);
          state_d.head_pending = 1'b0;
          state_d = close_unit(state_d);
          if (!state_d.scan_finished) begin
            state_d.expect_header = 1'b1;
          end
        end else begin
          // ordinary byte releases the held byte and pending zeros
          bundle = push(bundle, state_d.unit_kind, state_d.held_byte,
                        state_d.head_pending, 1'b0);
          state_d.head_pending = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < state_d.zero_run) begin
              bundle = push(bundle, state_d.unit_kind, ByteZero, 1'b0, 1'b0);
            end
          end
          state_d.zero_run  = 2'd0;
          state_d.held_byte = b;
        end
      end else begin
        // outside any unit: hunt for a start code
        if (b == ByteZero) begin
          if (state_d.zero_run != 2'd3) begin
            state_d.zero_run = state_d.zero_run + 2'd1;
          end
        end else begin
          if (b == ByteOne && state_d.zero_run >= 2'd2) begin
            state_d.expect_header = 1'b1;
          end
          state_d.zero_run = 2'd0;
        end
      end

      // buffer end closes an open unit with its trailing zeros
      if (item_i.buffer_end && state_d.inside_unit) begin
        bundle = push(bundle, state_d.unit_kind, state_d.held_byte,
                      state_d.head_pending, (state_d.zero_run == 2'd0));
        state_d.head_pending = 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < state_d.zero_run) begin
            bundle = push(bundle, state_d.unit_kind, ByteZero, 1'b0,
                          (2'(k + 1) == state_d.zero_run));
          end
        end
        state_d = close_unit(state_d);
      end
    end

    // closing status rides on the last result of the buffer
    if (item_i.buffer_end) begin
      if (bundle.count == '0) begin
        bundle.res[0] = '0;
        bundle.count  = ResCntW'(1);
      end
      tail = ResIdxW'(bundle.count - 1'b1);
      bundle.res[tail].scan_done   = 1'b1;
      bundle.res[tail].both_found  = state_d.sps_seen && state_d.pps_seen;
      state_d.held_byte     = ByteZero;
      state_d.zero_run      = 2'd0;
      state_d.inside_unit   = 1'b0;
      state_d.expect_header = 1'b0;
      state_d.head_pending  = 1'b0;
      state_d.unit_kind     = KIND_OTHER;
      state_d.scan_finished = 1'b0;
      state_d.in_buffer     = 1'b0;
    end

    // flag the final result of this item
    if (bundle.count != '0) begin
      tail = ResIdxW'(bundle.count - 1'b1);
      bundle.res[tail].last_result = 1'b1;
    end
  end

  assign bundle_o = bundle;

  // scan state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/pse_res_buf.sv
// ----------------------------------------------------------------------------
// pse_res_buf
// Result register: holds the bundle of one item and hands its results out
// one beat at a time; reports when a new bundle may be loaded.
// ----------------------------------------------------------------------------
module pse_res_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pse_pkg::pse_bundle_t bundle_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  output pse_pkg::pse_out_t    out_o,
  input  logic                 out_stall_i
);
  import pse_pkg::*;

  pse_out_t [MaxResults-1:0] res_q;
  logic [ResCntW-1:0]        count_q;
  logic [ResIdxW-1:0]        idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic                      take, last_beat;

  // beat handoff
  assign take      = valid_q && !out_stall_i;
  assign last_beat = (ResCntW'(idx_q) + ResCntW'(1)) == count_q;
  assign free_o    = !valid_q || (take && last_beat);

  assign out_valid_o = valid_q;
  assign out_o       = res_q[idx_q];

  // read pointer and occupancy
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      idx_d   = '0;
      valid_d = (bundle_i.count != '0);
    end else if (take) begin
      if (last_beat) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
      if (load_i) begin
        count_q <= bundle_i.count;
      end
    end
  end

  // bundle payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

FILE: design/h264_param_set_extractor.sv
// Path: the first result of a byte passes the input register, then the
// result register, before it is presented; it waits in the input register
// while the result register is busy.
// Throughput: one byte per cycle while the output does not stall and each
// byte yields at most one result; more results hold the result register.
// Reset: all scan state, both known flags and both stages clear at once.
// ----------------------------------------------------------------------------
// h264_param_set_extractor
// Annex B start code parser that passes out the bytes of sequence and
// picture parameter set units, tagged, with a closing status per buffer.
// ----------------------------------------------------------------------------
module h264_param_set_extractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i,
  // byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pse_pkg::pse_in_t  in_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pse_pkg::pse_out_t out_o
);
  import pse_pkg::*;

  logic        sps_known_q, pps_known_q;
  logic        in_valid_q;
  pse_in_t     in_item_q;
  logic        buf_free, load;
  pse_bundle_t bundle;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_known_q <= 1'b0;
      pps_known_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSpsKnown: sps_known_q <= cfg_data_i;
        CfgPpsKnown: pps_known_q <= cfg_data_i;
        default:     sps_known_q <= sps_known_q;
      endcase
    end
  end

  // input register, drained into the result register
  assign load       = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_i;
    end
  end

  // scan logic
  pse_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .item_i      (in_item_q),
    .sps_known_i (sps_known_q),
    .pps_known_i (pps_known_q),
    .bundle_o    (bundle)
  );

  // result register
  pse_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // closing status always ends the results of its item
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.scan_done |-> out_o.last_result)
    else $error("scan_done result not marked last");

  // a result without payload only carries the closing status
  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.byte_valid |-> out_o.scan_done && !out_o.unit_first)
    else $error("empty result without closing status");

  // a byte is only held back while the result register is busy
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while result register empty");
`endif

endmodule
